FILE: rtl/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared types and codes for the log record deframer.
// ----------------------------------------------------------------------------
package lrd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned KindW  = 2;

  // Opcodes carried in the first byte of a record
  localparam logic [ByteW-1:0] OP_PUT = 8'd1;
  localparam logic [ByteW-1:0] OP_DEL = 8'd2;

  // Record kinds reported on record_op
  localparam logic [KindW-1:0] REC_PUT     = 2'd0;
  localparam logic [KindW-1:0] REC_DEL     = 2'd1;
  localparam logic [KindW-1:0] REC_UNKNOWN = 2'd2;

  // Payload tags reported on byte_kind
  localparam logic [KindW-1:0] BK_NONE  = 2'd0;
  localparam logic [KindW-1:0] BK_KEY   = 2'd1;
  localparam logic [KindW-1:0] BK_VALUE = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic [KindW-1:0]  byte_kind;
    logic [KindW-1:0]  record_op;
    logic              record_end;
    logic              header_error;
    logic              body_truncated;
    logic              replay_done;
    logic [CountW-1:0] ops_replayed;
  } lrd_result_t;

  function automatic logic [KindW-1:0] kind_of(input logic [ByteW-1:0] op);
    logic [KindW-1:0] k;
    if (op == OP_PUT) begin
      k = REC_PUT;
    end else if (op == OP_DEL) begin
      k = REC_DEL;
    end else begin
      k = REC_UNKNOWN;
    end
    return k;
  endfunction

endpackage

FILE: rtl/lrd_parser.sv
// ----------------------------------------------------------------------------
// lrd_parser
// Record phase tracking: consumes one stream beat per cycle while take_i is
// high and forms the result for it from the registered parse state.
// ----------------------------------------------------------------------------
module lrd_parser
  import lrd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [ByteW-1:0]  log_byte_i,
  input  logic              stream_end_i,
  output logic              has_result_o,
  output lrd_result_t       result_o
);

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_HEADER,
    PH_KEY,
    PH_VALUE
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [2:0]        hidx_q, hidx_d;
  logic [KindW-1:0]  kind_q, kind_d;
  logic              is_put_q, is_put_d;
  logic [LenW-1:0]   key_len_q, key_len_d;
  logic [LenW-1:0]   val_len_q, val_len_d;
  logic [LenW-1:0]   left_q, left_d;
  logic [CountW-1:0] count_q, count_d;

  logic [CountW-1:0] count_inc;
  logic [LenW-1:0]   left_dec;
  logic [4:0]        lane_sh;

  assign count_inc = (count_q != {CountW{1'b1}}) ? count_q + 1'b1 : count_q;
  assign left_dec  = left_q - 1'b1;
  assign lane_sh   = {hidx_q[1:0], 3'b000};

  always_comb begin
    phase_d      = phase_q;
    hidx_d       = hidx_q;
    kind_d       = kind_q;
    is_put_d     = is_put_q;
    key_len_d    = key_len_q;
    val_len_d    = val_len_q;
    left_d       = left_q;
    count_d      = count_q;
    has_result_o = 1'b0;
    result_o     = '0;

    if (stream_end_i) begin
      has_result_o         = 1'b1;
      result_o.replay_done = 1'b1;
      if (phase_q != PH_OPCODE) begin
        result_o.record_op = kind_q;
      end
      result_o.ops_replayed = count_q;
      if (phase_q == PH_HEADER) begin
        result_o.header_error = 1'b1;
      end else if (phase_q == PH_KEY || phase_q == PH_VALUE) begin
        result_o.body_truncated = 1'b1;
        result_o.record_end     = 1'b1;
        result_o.ops_replayed   = count_inc;
      end
      // new stream starts from scratch
      phase_d   = PH_OPCODE;
      hidx_d    = '0;
      kind_d    = REC_PUT;
      is_put_d  = 1'b0;
      key_len_d = '0;
      val_len_d = '0;
      left_d    = '0;
      count_d   = '0;
    end else begin
      case (phase_q)
        PH_OPCODE: begin
          kind_d    = kind_of(log_byte_i);
          is_put_d  = (log_byte_i == OP_PUT);
          hidx_d    = '0;
          key_len_d = '0;
          val_len_d = '0;
          phase_d   = PH_HEADER;
        end
        PH_HEADER: begin
          if (!hidx_q[2]) begin
            key_len_d[lane_sh +: ByteW] = key_len_q[lane_sh +: ByteW] | log_byte_i;
          end else begin
            val_len_d[lane_sh +: ByteW] = val_len_q[lane_sh +: ByteW] | log_byte_i;
          end
          hidx_d = hidx_q + 1'b1;
          if (hidx_q == 3'd7) begin
            if (key_len_d != '0) begin
              phase_d = PH_KEY;
              left_d  = key_len_d;
            end else if (is_put_q && val_len_d != '0) begin
              phase_d = PH_VALUE;
              left_d  = val_len_d;
            end else begin
              // empty record closes on its last header byte
              phase_d               = PH_OPCODE;
              left_d                = '0;
              count_d               = count_inc;
              has_result_o          = 1'b1;
              result_o.record_op    = kind_q;
              result_o.record_end   = 1'b1;
              result_o.ops_replayed = count_inc;
            end
          end
        end
        PH_KEY: begin
          has_result_o          = 1'b1;
          result_o.data_byte    = log_byte_i;
          result_o.byte_kind    = BK_KEY;
          result_o.record_op    = kind_q;
          result_o.ops_replayed = count_q;
          left_d                = left_dec;
          if (left_dec == '0) begin
            if (is_put_q && val_len_q != '0) begin
              phase_d = PH_VALUE;
              left_d  = val_len_q;
            end else begin
              phase_d               = PH_OPCODE;
              count_d               = count_inc;
              result_o.record_end   = 1'b1;
              result_o.ops_replayed = count_inc;
            end
          end
        end
        PH_VALUE: begin
          has_result_o          = 1'b1;
          result_o.data_byte    = log_byte_i;
          result_o.byte_kind    = BK_VALUE;
          result_o.record_op    = kind_q;
          result_o.ops_replayed = count_q;
          left_d                = left_dec;
          if (left_dec == '0) begin
            phase_d               = PH_OPCODE;
            count_d               = count_inc;
            result_o.record_end   = 1'b1;
            result_o.ops_replayed = count_inc;
          end
        end
        default: begin
          phase_d = PH_OPCODE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_OPCODE;
      hidx_q    <= '0;
      kind_q    <= REC_PUT;
      is_put_q  <= 1'b0;
      key_len_q <= '0;
      val_len_q <= '0;
      left_q    <= '0;
      count_q   <= '0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      hidx_q    <= hidx_d;
      kind_q    <= kind_d;
      is_put_q  <= is_put_d;
      key_len_q <= key_len_d;
      val_len_q <= val_len_d;
      left_q    <= left_d;
      count_q   <= count_d;
    end
  end

endmodule

FILE: rtl/lrd_out_buf.sv
// ----------------------------------------------------------------------------
// lrd_out_buf
// Result register with a skid entry; ready comes straight from a flop.
// ----------------------------------------------------------------------------
module lrd_out_buf
  import lrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  lrd_result_t result_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output lrd_result_t result_o,
  output logic        skid_full_o
);

  logic        main_vld_q, skid_vld_q;
  lrd_result_t main_q, skid_q;
  logic        pop;

  assign pop         = main_vld_q && out_ready_i;
  assign room_o      = !skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign result_o    = main_q;
  assign skid_full_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        main_vld_q <= push_i;
      end
    end else if (push_i) begin
      if (!main_vld_q) begin
        main_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= result_i;
      end
    end else if (push_i) begin
      if (!main_vld_q) begin
        main_q <= result_i;
      end else begin
        skid_q <= result_i;
      end
    end
  end

endmodule

FILE: rtl/log_record_deframer_core.sv
// ----------------------------------------------------------------------------
// log_record_deframer_core
// Write-ahead log deframer: splits a byte stream into tagged key/value beats.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): one beat per log byte, or a beat
// with stream_end_i set that closes the stream and carries no byte.
// Output channel (out_valid_o / out_ready_i): zero or one result beat per
// input beat. Opcode and length bytes give no beat, except the last length
// byte of a record with an empty body, which reports its record_end. Key and
// value bytes and stream-end beats always give one.
// Results are registered in the result register or the skid entry before they
// reach the output. Throughput: one input beat per cycle while the skid entry
// is empty, set by the parse state registers that update each accepted beat.
// Stall: results sit in a result register plus one skid entry; in_ready_o
// drops only once the skid entry is occupied, so a stalled receiver backs up
// the source after at most two buffered results.
// Reset: parse state returns to waiting for an opcode with the record count
// cleared, and both buffer entries are emptied. A stream-end beat does the
// same to the parse state, so the next byte starts a new stream.
// ----------------------------------------------------------------------------
module log_record_deframer_core
  import lrd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  log_byte_i,
  input  logic              stream_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ByteW-1:0]  data_byte_o,
  output logic [KindW-1:0]  byte_kind_o,
  output logic [KindW-1:0]  record_op_o,
  output logic              record_end_o,
  output logic              header_error_o,
  output logic              body_truncated_o,
  output logic              replay_done_o,
  output logic [CountW-1:0] ops_replayed_o
);

  logic        take;
  logic        has_result;
  logic        room;
  logic        skid_full;
  lrd_result_t parse_res;
  lrd_result_t out_res;

  // a beat is consumed whenever the buffer can absorb its possible result
  assign in_ready_o = room;
  assign take       = in_valid_i && room;

  lrd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .log_byte_i   (log_byte_i),
    .stream_end_i (stream_end_i),
    .has_result_o (has_result),
    .result_o     (parse_res)
  );

  // only beats that produce a result are pushed
  lrd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take && has_result),
    .result_i    (parse_res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res),
    .skid_full_o (skid_full)
  );

  assign data_byte_o      = out_res.data_byte;
  assign byte_kind_o      = out_res.byte_kind;
  assign record_op_o      = out_res.record_op;
  assign record_end_o     = out_res.record_end;
  assign header_error_o   = out_res.header_error;
  assign body_truncated_o = out_res.body_truncated;
  assign replay_done_o    = out_res.replay_done;
  assign ops_replayed_o   = out_res.ops_replayed;

  // skid entry is only ever filled behind a valid result register
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full |-> out_valid_o)
    else $error("skid entry holds a result while the output register is empty");

  // a full skid entry must block the input side
  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full |-> !in_ready_o)
    else $error("input accepted with no buffer room");

  // a cut header is reported only on a stream-end beat and never closes a record
  a_header_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && header_error_o) |-> (replay_done_o && !record_end_o))
    else $error("header error outside a stream-end result");

  // a cut body always closes its record at stream end, with no payload byte
  a_trunc_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && body_truncated_o) |->
      (replay_done_o && record_end_o && byte_kind_o == BK_NONE))
    else $error("truncation flag with inconsistent result fields");

endmodule
